/* rtl/core/crpt_pkg.sv */
package crpt_pkg;

    localparam int A_W    = 34;
    localparam int B_W    = 21;
    localparam int H_W    = A_W + 3;
    localparam int P_W    = H_W + B_W;
    localparam int CNT_W  = 5;
    localparam int Q_W    = 20;
    localparam int R_W    = 41;
    localparam int C_W    = 44;
    localparam int Z_W    = 20;
    localparam int ATAN_N = 24;
    localparam int LANES  = 4;

    localparam logic signed [Z_W-1:0] PI_Q16 = 20'sd205887;
    localparam logic [15:0] GAIN_RESET = 16'd6400;

    localparam logic [1:0] REG_X_GAIN   = 2'd0;
    localparam logic [1:0] REG_Y_GAIN   = 2'd1;
    localparam logic [1:0] REG_YAW_GAIN = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    function automatic logic [16:0] atan_q16(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:  v = 17'd51472;
            5'd1:  v = 17'd30385;
            5'd2:  v = 17'd16055;
            5'd3:  v = 17'd8150;
            5'd4:  v = 17'd4091;
            5'd5:  v = 17'd2047;
            5'd6:  v = 17'd1024;
            5'd7:  v = 17'd512;
            5'd8:  v = 17'd256;
            5'd9:  v = 17'd128;
            5'd10: v = 17'd64;
            5'd11: v = 17'd32;
            5'd12: v = 17'd16;
            5'd13: v = 17'd8;
            5'd14: v = 17'd4;
            5'd15: v = 17'd2;
            5'd16: v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/crpt_mac.sv */
module crpt_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [crpt_pkg::A_W-1:0]      i_a [crpt_pkg::LANES],
    input  logic signed [crpt_pkg::B_W-1:0]      i_b [crpt_pkg::LANES],
    output crpt_pkg::t_unit_stat                 o_stat,
    output logic signed [crpt_pkg::P_W-1:0]      o_prod
);

    logic signed [crpt_pkg::A_W-1:0] r_a [crpt_pkg::LANES];
    logic signed [crpt_pkg::B_W-1:0] r_b [crpt_pkg::LANES];
    logic signed [crpt_pkg::H_W-1:0] r_hi;
    logic [crpt_pkg::B_W-1:0]        r_lo;
    logic [crpt_pkg::CNT_W-1:0]      r_cnt;
    logic                            r_busy;
    logic                            r_done;
    logic signed [crpt_pkg::H_W-1:0] pp;
    logic signed [crpt_pkg::H_W-1:0] n_sum;
    logic                            last;

    assign last = (r_cnt == crpt_pkg::CNT_W'(crpt_pkg::B_W - 1));

    // one multiplier bit of every lane per cycle, sign bit weighs negative
    always_comb begin
        pp = '0;
        for (int i = 0; i < crpt_pkg::LANES; i++) begin
            if (r_b[i][0]) begin
                pp = pp + crpt_pkg::H_W'(r_a[i]);
            end
        end
        if (last) begin
            pp = -pp;
        end
        n_sum = r_hi + pp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_hi   <= '0;
                r_lo   <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_hi <= n_sum >>> 1;
                r_lo <= {n_sum[0], r_lo[crpt_pkg::B_W-1:1]};
                for (int i = 0; i < crpt_pkg::LANES; i++) begin
                    r_b[i] <= r_b[i] >>> 1;
                end
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = $signed({r_hi, r_lo});

endmodule

/* rtl/core/crpt_cordic.sv */
module crpt_cordic #(
    parameter int ITERS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [crpt_pkg::R_W-1:0]      i_x,
    input  logic signed [crpt_pkg::R_W-1:0]      i_y,
    output crpt_pkg::t_unit_stat                 o_stat,
    output logic signed [crpt_pkg::Z_W-1:0]      o_angle
);

    localparam int N = (ITERS < crpt_pkg::ATAN_N) ? ITERS : crpt_pkg::ATAN_N;

    logic signed [crpt_pkg::C_W-1:0] r_x;
    logic signed [crpt_pkg::C_W-1:0] r_y;
    logic signed [crpt_pkg::Z_W-1:0] r_z;
    logic [4:0]                      r_i;
    logic                            r_busy;
    logic                            r_done;
    logic signed [crpt_pkg::C_W-1:0] xs;
    logic signed [crpt_pkg::C_W-1:0] ys;
    logic signed [crpt_pkg::Z_W-1:0] at;

    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;
    assign at = $signed(crpt_pkg::Z_W'(crpt_pkg::atan_q16(r_i)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_i <= '0;
                if (i_x == '0 && i_y == '0) begin
                    r_z    <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    if (i_x[crpt_pkg::R_W-1]) begin
                        r_x <= -crpt_pkg::C_W'(i_x);
                        r_y <= -crpt_pkg::C_W'(i_y);
                        r_z <= i_y[crpt_pkg::R_W-1] ? -crpt_pkg::PI_Q16 : crpt_pkg::PI_Q16;
                    end else begin
                        r_x <= crpt_pkg::C_W'(i_x);
                        r_y <= crpt_pkg::C_W'(i_y);
                        r_z <= '0;
                    end
                end
            end else if (r_busy) begin
                if (!r_y[crpt_pkg::C_W-1]) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end
                r_i <= r_i + 1'b1;
                if (r_i == 5'(N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_angle     = r_z;

endmodule

/* rtl/core/clutch_relative_pose_to_twist_core.sv */
// with the clutch held: nine bit-serial multiply passes and a cordic of ANGLE_ITERATIONS
// (at most 24) iterations run between the accepted word and the loaded result; with the
// clutch released the passes are skipped and zero velocities are loaded
// one word is worked on at a time and the next is taken the cycle after the result is
// loaded, and an output stall holds off the loading
// reset (synchronous, active low) clears the latch, empties the output and loads 25.0 gains
module clutch_relative_pose_to_twist_core #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_clutch,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_active,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic signed [31:0] o_yaw_rate,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAC  = 2'd1;
    localparam logic [1:0] S_ANG  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [3:0] OP_QW    = 4'd0;
    localparam logic [3:0] OP_QX    = 4'd1;
    localparam logic [3:0] OP_QY    = 4'd2;
    localparam logic [3:0] OP_QZ    = 4'd3;
    localparam logic [3:0] OP_R00   = 4'd4;
    localparam logic [3:0] OP_R10   = 4'd5;
    localparam logic [3:0] OP_VELX  = 4'd6;
    localparam logic [3:0] OP_VELY  = 4'd7;
    localparam logic [3:0] OP_YAW   = 4'd8;

    localparam int A_W = crpt_pkg::A_W;
    localparam int B_W = crpt_pkg::B_W;
    localparam int P_W = crpt_pkg::P_W;
    localparam int Q_W = crpt_pkg::Q_W;
    localparam int R_W = crpt_pkg::R_W;
    localparam int Z_W = crpt_pkg::Z_W;

    logic [1:0]  r_state;
    logic [3:0]  r_op;
    logic        r_kick;
    logic        r_cstart;
    logic [15:0] r_x_gain;
    logic [15:0] r_y_gain;
    logic [15:0] r_yaw_gain;
    logic        r_latched;

    logic signed [31:0] r_ref_x;
    logic signed [31:0] r_ref_y;
    logic signed [15:0] r_ref_q [4];
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [15:0] r_cq [4];
    logic signed [Q_W-1:0] r_q [4];
    logic signed [R_W-1:0] r_r00;
    logic signed [R_W-1:0] r_r10;
    logic signed [Z_W-1:0] r_ang;
    logic signed [31:0] r_vx;
    logic signed [31:0] r_vy;
    logic signed [31:0] r_vyaw;
    logic               r_act;

    logic               r_ovalid;
    logic               r_oact;
    logic signed [31:0] r_ovx;
    logic signed [31:0] r_ovy;
    logic signed [31:0] r_oyaw;

    logic signed [A_W-1:0] op_a [crpt_pkg::LANES];
    logic signed [B_W-1:0] op_b [crpt_pkg::LANES];
    crpt_pkg::t_unit_stat  mac_stat;
    crpt_pkg::t_unit_stat  cor_stat;
    logic signed [P_W-1:0] prod;
    logic signed [Z_W-1:0] cor_angle;

    logic                  accept;
    logic                  cfg_wr;
    logic signed [35:0]    n_round;
    logic signed [Q_W-1:0] n_q;
    logic signed [P_W-9:0] sh;
    logic signed [31:0]    n_sat;

    assign accept = i_valid && !o_stall;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign o_stall = (r_state != S_IDLE);
    assign pready  = 1'b1;

    always_comb begin
        case (paddr[3:2])
            crpt_pkg::REG_X_GAIN:   prdata = {16'd0, r_x_gain};
            crpt_pkg::REG_Y_GAIN:   prdata = {16'd0, r_y_gain};
            crpt_pkg::REG_YAW_GAIN: prdata = {16'd0, r_yaw_gain};
            default:                prdata = '0;
        endcase
    end

    // operand routing per pass; conjugate of the reference folded into signs
    always_comb begin
        for (int i = 0; i < crpt_pkg::LANES; i++) begin
            op_a[i] = '0;
            op_b[i] = '0;
        end
        case (r_op)
            OP_QW: begin
                op_a[0] = A_W'(r_ref_q[0]);  op_b[0] = B_W'(r_cq[0]);
                op_a[1] = A_W'(r_ref_q[1]);  op_b[1] = B_W'(r_cq[1]);
                op_a[2] = A_W'(r_ref_q[2]);  op_b[2] = B_W'(r_cq[2]);
                op_a[3] = A_W'(r_ref_q[3]);  op_b[3] = B_W'(r_cq[3]);
            end
            OP_QX: begin
                op_a[0] = A_W'(r_ref_q[0]);  op_b[0] = B_W'(r_cq[1]);
                op_a[1] = -A_W'(r_ref_q[1]); op_b[1] = B_W'(r_cq[0]);
                op_a[2] = -A_W'(r_ref_q[2]); op_b[2] = B_W'(r_cq[3]);
                op_a[3] = A_W'(r_ref_q[3]);  op_b[3] = B_W'(r_cq[2]);
            end
            OP_QY: begin
                op_a[0] = A_W'(r_ref_q[0]);  op_b[0] = B_W'(r_cq[2]);
                op_a[1] = A_W'(r_ref_q[1]);  op_b[1] = B_W'(r_cq[3]);
                op_a[2] = -A_W'(r_ref_q[2]); op_b[2] = B_W'(r_cq[0]);
                op_a[3] = -A_W'(r_ref_q[3]); op_b[3] = B_W'(r_cq[1]);
            end
            OP_QZ: begin
                op_a[0] = A_W'(r_ref_q[0]);  op_b[0] = B_W'(r_cq[3]);
                op_a[1] = -A_W'(r_ref_q[1]); op_b[1] = B_W'(r_cq[2]);
                op_a[2] = A_W'(r_ref_q[2]);  op_b[2] = B_W'(r_cq[1]);
                op_a[3] = -A_W'(r_ref_q[3]); op_b[3] = B_W'(r_cq[0]);
            end
            OP_R00: begin
                op_a[0] = A_W'(r_q[2]);      op_b[0] = B_W'(r_q[2]);
                op_a[1] = A_W'(r_q[3]);      op_b[1] = B_W'(r_q[3]);
            end
            OP_R10: begin
                op_a[0] = A_W'(r_q[1]);      op_b[0] = B_W'(r_q[2]);
                op_a[1] = A_W'(r_q[0]);      op_b[1] = B_W'(r_q[3]);
            end
            OP_VELX: begin
                op_a[0] = A_W'(r_py) - A_W'(r_ref_y);
                op_b[0] = B_W'($signed({1'b0, r_x_gain}));
            end
            OP_VELY: begin
                op_a[0] = A_W'(r_ref_x) - A_W'(r_px);
                op_b[0] = B_W'($signed({1'b0, r_y_gain}));
            end
            OP_YAW: begin
                op_a[0] = -A_W'(r_ang);
                op_b[0] = B_W'($signed({1'b0, r_yaw_gain}));
            end
            default: begin
                op_a[0] = '0;
            end
        endcase
    end

    // rounding to q14 and saturation of the scaled result
    always_comb begin
        n_round = prod[35:0] + 36'sd8192;
        n_q     = n_round[33:14];
        sh      = prod[P_W-1:8];
        if (sh > (P_W-8)'(64'sd2147483647)) begin
            n_sat = 32'sh7fffffff;
        end else if (sh < -(P_W-8)'(64'sd2147483648)) begin
            n_sat = 32'sh80000000;
        end else begin
            n_sat = sh[31:0];
        end
    end

    crpt_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_stat  (mac_stat),
        .o_prod  (prod)
    );

    crpt_cordic #(
        .ITERS (ANGLE_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cstart),
        .i_x     (r_r00),
        .i_y     (r_r10),
        .o_stat  (cor_stat),
        .o_angle (cor_angle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_op       <= OP_QW;
            r_kick     <= 1'b0;
            r_cstart   <= 1'b0;
            r_x_gain   <= crpt_pkg::GAIN_RESET;
            r_y_gain   <= crpt_pkg::GAIN_RESET;
            r_yaw_gain <= crpt_pkg::GAIN_RESET;
            r_latched  <= 1'b0;
            r_ref_x    <= '0;
            r_ref_y    <= '0;
            for (int i = 0; i < 4; i++) begin
                r_ref_q[i] <= '0;
            end
            r_ovalid   <= 1'b0;
        end else begin
            r_kick   <= 1'b0;
            r_cstart <= 1'b0;
            if (cfg_wr) begin
                case (paddr[3:2])
                    crpt_pkg::REG_X_GAIN:   r_x_gain   <= pwdata[15:0];
                    crpt_pkg::REG_Y_GAIN:   r_y_gain   <= pwdata[15:0];
                    crpt_pkg::REG_YAW_GAIN: r_yaw_gain <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (r_ovalid && !i_stall && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_px      <= i_pos_x;
                        r_py      <= i_pos_y;
                        r_cq[0]   <= i_quat_w;
                        r_cq[1]   <= i_quat_x;
                        r_cq[2]   <= i_quat_y;
                        r_cq[3]   <= i_quat_z;
                        r_latched <= i_clutch;
                        r_act     <= i_clutch;
                        if (i_clutch && !r_latched) begin
                            r_ref_x    <= i_pos_x;
                            r_ref_y    <= i_pos_y;
                            r_ref_q[0] <= i_quat_w;
                            r_ref_q[1] <= i_quat_x;
                            r_ref_q[2] <= i_quat_y;
                            r_ref_q[3] <= i_quat_z;
                        end
                        if (i_clutch) begin
                            r_op    <= OP_QW;
                            r_kick  <= 1'b1;
                            r_state <= S_MAC;
                        end else begin
                            r_vx    <= '0;
                            r_vy    <= '0;
                            r_vyaw  <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_MAC: begin
                    if (mac_stat.done) begin
                        case (r_op)
                            OP_QW, OP_QX, OP_QY, OP_QZ: r_q[r_op[1:0]] <= n_q;
                            OP_R00: r_r00 <= R_W'(64'sd268435456) - {prod[R_W-2:0], 1'b0};
                            OP_R10: r_r10 <= {prod[R_W-2:0], 1'b0};
                            OP_VELX: r_vx   <= n_sat;
                            OP_VELY: r_vy   <= n_sat;
                            OP_YAW:  r_vyaw <= n_sat;
                            default: ;
                        endcase
                        if (r_op == OP_R10) begin
                            r_cstart <= 1'b1;
                            r_state  <= S_ANG;
                        end else if (r_op == OP_YAW) begin
                            r_state <= S_OUT;
                        end else begin
                            r_op   <= r_op + 1'b1;
                            r_kick <= 1'b1;
                        end
                    end
                end
                S_ANG: begin
                    if (cor_stat.done) begin
                        r_ang   <= cor_angle;
                        r_op    <= OP_VELX;
                        r_kick  <= 1'b1;
                        r_state <= S_MAC;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_oact   <= r_act;
                        r_ovx    <= r_vx;
                        r_ovy    <= r_vy;
                        r_oyaw   <= r_vyaw;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid    = r_ovalid;
    assign o_active   = r_oact;
    assign o_vel_x    = r_ovx;
    assign o_vel_y    = r_ovy;
    assign o_yaw_rate = r_oyaw;

endmodule
